>>> rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, types and helper functions for the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int COUNT_BITS = 16;
  localparam int POS_BITS   = 32;
  localparam int CORDIC_N   = 17;
  localparam int DIV_BITS   = 52;
  localparam int IN_DW      = 56;
  localparam int OUT_DW     = 152;

  localparam logic signed [20:0] ANG_PI      = 21'sd205887;
  localparam logic signed [20:0] ANG_HALF_PI = 21'sd102944;
  localparam logic signed [20:0] ANG_2PI     = 21'sd411774;
  localparam logic signed [17:0] UNWRAP_LIM  = 18'sd10000;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [32:0] US_PER_S    = 33'sd1000000;

  typedef enum logic [2:0] {
    REG_DIST_PER_TICK = 3'd0,
    REG_INV_BASE      = 3'd1,
    REG_START_X       = 3'd2,
    REG_START_Y       = 3'd3,
    REG_START_HEAD    = 3'd4,
    REG_TRACK_EN      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  function automatic logic signed [21:0] atan_at(input logic [4:0] i);
    case (i)
      5'd0:    atan_at = 22'sd51472;
      5'd1:    atan_at = 22'sd30386;
      5'd2:    atan_at = 22'sd16055;
      5'd3:    atan_at = 22'sd8150;
      5'd4:    atan_at = 22'sd4091;
      5'd5:    atan_at = 22'sd2047;
      5'd6:    atan_at = 22'sd1024;
      5'd7:    atan_at = 22'sd512;
      5'd8:    atan_at = 22'sd256;
      5'd9:    atan_at = 22'sd128;
      5'd10:   atan_at = 22'sd64;
      5'd11:   atan_at = 22'sd32;
      5'd12:   atan_at = 22'sd16;
      5'd13:   atan_at = 22'sd8;
      5'd14:   atan_at = 22'sd4;
      5'd15:   atan_at = 22'sd2;
      5'd16:   atan_at = 22'sd1;
      default: atan_at = 22'sd0;
    endcase
  endfunction

  function automatic logic signed [20:0] wrap_ang(input logic signed [20:0] h);
    if (h > ANG_PI) wrap_ang = h - ANG_2PI;
    else if (h < -ANG_PI) wrap_ang = h + ANG_2PI;
    else wrap_ang = h;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -40'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

>>> rtl/ddo_isqrt.sv
// ----------------------------------------------------------------------------
// ddo_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ddo_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] radicand,
  output logic [16:0] root,
  output logic        done
);
  import ddo_pkg::*;

  logic [33:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [33:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    if (n_r >= trial) begin
      n_nxt   = n_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      n_nxt   = n_r;
      res_nxt = res_r >> 1;
    end
    bit_nxt = bit_r >> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= {1'b0, radicand};
        res_r  <= '0;
        bit_r  <= 34'h1_0000_0000;
        cnt_r  <= 5'd17;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        n_r   <= n_nxt;
        res_r <= res_nxt;
        bit_r <= bit_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = res_r[16:0];
  assign done = done_r;
endmodule

>>> rtl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ddo_pkg::cordic_ctl_t     ctl,
  input  logic signed [33:0]       x0,
  input  logic signed [33:0]       y0,
  input  logic signed [21:0]       z0,
  output logic signed [33:0]       x_out,
  output logic signed [33:0]       y_out,
  output logic signed [21:0]       z_out,
  output logic                     busy,
  output logic                     done
);
  import ddo_pkg::*;

  logic signed [33:0] x_r, y_r, xs, ys;
  logic signed [21:0] z_r;
  logic [4:0]         i_r;
  logic               vec_r, busy_r, done_r, dir_pos;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign dir_pos = vec_r ? !(y_r > 34'sd0) : (z_r >= 22'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        x_r    <= x0;
        y_r    <= y0;
        z_r    <= z0;
        vec_r  <= ctl.vectoring;
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (dir_pos) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_at(i_r);
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_at(i_r);
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(CORDIC_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign busy  = busy_r;
  assign done  = done_r;
endmodule

>>> rtl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ddo_pkg::DIV_BITS-1:0] dividend,
  input  logic [19:0]                  divisor,
  output logic [ddo_pkg::DIV_BITS-1:0] quotient,
  output logic                         busy,
  output logic                         done
);
  import ddo_pkg::*;

  logic [DIV_BITS-1:0] q_r;
  logic [19:0]         d_r;
  logic [20:0]         rem_r, r2;
  logic [5:0]          cnt_r;
  logic                busy_r, done_r;

  assign r2 = {rem_r[19:0], q_r[DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
        cnt_r  <= 6'(DIV_BITS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (r2 >= {1'b0, d_r}) begin
          rem_r <= r2 - {1'b0, d_r};
          q_r   <= {q_r[DIV_BITS-2:0], 1'b1};
        end else begin
          rem_r <= r2;
          q_r   <= {q_r[DIV_BITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = q_r;
  assign busy     = busy_r;
  assign done     = done_r;
endmodule

>>> rtl/diff_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// An item's work covers at most the two wheels, the asin and both speed
// divisions. Throughput: one item at a time, in_tready is low while an item
// is in work or its result waits for the output register.
// Reset (rst_n, synchronous): registers to defaults, pose and speeds zero.
// ----------------------------------------------------------------------------
// diff_drive_odometry_top
// Wheel odometry: encoder counts to travel, asin heading, CORDIC dead reckoning.
// ----------------------------------------------------------------------------
module diff_drive_odometry_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // right_count[15:0], left_count[31:16], elapsed_us[51:32], zero pad
  input  logic [ddo_pkg::IN_DW-1:0]    in_tdata,
  // sample_present
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // pos_x[31:0], pos_y[63:32], heading[82:64], linear_speed[114:83],
  // turn_rate[146:115], zero pad
  output logic [ddo_pkg::OUT_DW-1:0]   out_tdata,
  // pose_held
  output logic                         out_tuser,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [31:0]                  cfg_wdata
);
  import ddo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_TICK, S_TRAV, S_CHK, S_ARG, S_SQ, S_SQW, S_ASW, S_MID, S_SCW,
    S_PX, S_PY, S_PH, S_DV1, S_DW1, S_DV2, S_DW2, S_OUT
  } state_t;

  state_t state_r;

  logic [19:0]        dpt_r, el_r;
  logic [23:0]        ibw_r;
  logic               track_r, side_r, neg_r, held_r, flip_r, out_valid_r, out_user_r;
  logic               dneg_r;
  logic signed [15:0] prev_right_r, prev_left_r, rc_r, lc_r;
  logic signed [31:0] right_trav_r, left_trav_r, pose_x_r, pose_y_r;
  logic signed [31:0] spd_fwd_r, spd_turn_r, dist_r;
  logic signed [18:0] head_r;
  logic signed [20:0] angle_r;
  logic [16:0]        m_r;
  logic [OUT_DW-1:0]  out_data_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p_r;

  logic signed [15:0] cnt_sel, prv_sel;
  logic signed [17:0] ticks_raw, ticks;
  logic signed [32:0] trav_sum, trav_diff;
  logic signed [65:0] prod_rnd, pos_rnd;
  logic signed [17:0] asin_arg;
  logic [16:0]        arg_mag;
  logic signed [20:0] head_ext, mid, mid_f;
  logic signed [33:0] cos_v, sin_v;
  logic signed [39:0] pos_sum;
  logic               div_neg;
  logic [DIV_BITS-1:0] div_mag, div_q;
  logic signed [31:0] speed_val;

  cordic_ctl_t        cor_ctl;
  logic signed [33:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [21:0] cor_z0, cor_z;
  logic               cor_busy, cor_done;
  logic               sq_start, sq_done;
  logic [16:0]        sq_root;
  logic               div_start, div_busy, div_done;

  // wheel ticks with counter unwrap
  assign cnt_sel   = side_r ? lc_r : rc_r;
  assign prv_sel   = side_r ? prev_left_r : prev_right_r;
  assign ticks_raw = 18'(cnt_sel) - 18'(prv_sel);
  always_comb begin
    if (ticks_raw > UNWRAP_LIM) ticks = ticks_raw - 18'sd65536;
    else if (ticks_raw < -UNWRAP_LIM) ticks = ticks_raw + 18'sd65536;
    else ticks = ticks_raw;
  end

  assign trav_sum  = 33'(right_trav_r) + 33'(left_trav_r);
  assign trav_diff = 33'(right_trav_r) - 33'(left_trav_r);
  assign prod_rnd  = (mul_p_r + 66'sd32768) >>> 16;
  assign asin_arg  = prod_rnd[17:0];
  assign arg_mag   = asin_arg[17] ? 17'(-asin_arg) : asin_arg[16:0];

  assign head_ext = 21'(head_r);
  assign mid      = wrap_ang((angle_r >>> 1) + head_ext);
  always_comb begin
    if (mid > ANG_HALF_PI) mid_f = mid - ANG_PI;
    else if (mid < -ANG_HALF_PI) mid_f = mid + ANG_PI;
    else mid_f = mid;
  end

  assign cos_v   = flip_r ? -cor_x : cor_x;
  assign sin_v   = flip_r ? -cor_y : cor_y;
  assign pos_rnd = (mul_p_r + 66'sd536870912) >>> 30;
  assign pos_sum = (state_r == S_PY) ? 40'(pose_x_r) + pos_rnd[39:0]
                                     : 40'(pose_y_r) + pos_rnd[39:0];

  assign div_neg = mul_p_r[65];
  assign div_mag = div_neg ? DIV_BITS'(-mul_p_r) : mul_p_r[DIV_BITS-1:0];
  always_comb begin
    if (dneg_r) begin
      if (div_q > DIV_BITS'(64'h8000_0000)) speed_val = 32'sh80000000;
      else speed_val = 32'(-div_q);
    end else begin
      if (div_q > DIV_BITS'(64'h7fff_ffff)) speed_val = 32'sh7fffffff;
      else speed_val = div_q[31:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TICK: begin
        mul_a = 33'(ticks);
        mul_b = 33'({1'b0, dpt_r});
      end
      S_CHK: begin
        mul_a = trav_diff;
        mul_b = 33'({1'b0, ibw_r});
      end
      S_ARG: begin
        mul_a = 33'({1'b0, arg_mag});
        mul_b = 33'({1'b0, arg_mag});
      end
      S_PX: begin
        mul_a = cos_v[32:0];
        mul_b = 33'(dist_r);
      end
      S_PY: begin
        mul_a = sin_v[32:0];
        mul_b = 33'(dist_r);
      end
      S_PH: begin
        mul_a = 33'(dist_r);
        mul_b = US_PER_S;
      end
      S_DW1: begin
        mul_a = 33'(angle_r);
        mul_b = US_PER_S;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  assign sq_start          = (state_r == S_SQ);
  assign cor_ctl.start     = (state_r == S_SQW && sq_done) || (state_r == S_MID);
  assign cor_ctl.vectoring = (state_r == S_SQW);
  assign cor_x0 = (state_r == S_SQW) ? 34'({sq_root, 14'b0}) : GAIN_Q30;
  assign cor_y0 = (state_r == S_SQW) ? 34'({m_r, 14'b0}) : 34'sd0;
  assign cor_z0 = (state_r == S_SQW) ? 22'sd0 : 22'(mid_f);
  assign div_start = (state_r == S_DV1) || (state_r == S_DV2);

  ddo_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (33'h1_0000_0000 - mul_p_r[32:0]),
    .root     (sq_root),
    .done     (sq_done)
  );

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cor_ctl),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .z0    (cor_z0),
    .x_out (cor_x),
    .y_out (cor_y),
    .z_out (cor_z),
    .busy  (cor_busy),
    .done  (cor_done)
  );

  ddo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (el_r),
    .quotient (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dpt_r        <= 20'd6918;
      ibw_r        <= 24'd218453;
      track_r      <= 1'b0;
      prev_right_r <= '0;
      prev_left_r  <= '0;
      right_trav_r <= '0;
      left_trav_r  <= '0;
      pose_x_r     <= '0;
      pose_y_r     <= '0;
      head_r       <= '0;
      spd_fwd_r    <= '0;
      spd_turn_r   <= '0;
      out_valid_r  <= 1'b0;
      side_r       <= 1'b0;
      held_r       <= 1'b0;
    end else begin
      if (out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          REG_DIST_PER_TICK: dpt_r    <= cfg_wdata[19:0];
          REG_INV_BASE:      ibw_r    <= cfg_wdata[23:0];
          REG_START_X:       pose_x_r <= cfg_wdata;
          REG_START_Y:       pose_y_r <= cfg_wdata;
          REG_START_HEAD:    head_r   <= cfg_wdata[18:0];
          REG_TRACK_EN:      track_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            rc_r   <= in_tdata[15:0];
            lc_r   <= in_tdata[31:16];
            el_r   <= in_tdata[51:32];
            side_r <= 1'b0;
            if (in_tuser) begin
              state_r <= S_TICK;
            end else begin
              right_trav_r <= '0;
              left_trav_r  <= '0;
              state_r      <= S_CHK;
            end
          end
        end
        S_TICK: begin
          if (cnt_sel == 16'sd0) begin
            side_r  <= 1'b1;
            state_r <= side_r ? S_CHK : S_TICK;
          end else begin
            if (side_r) prev_left_r <= lc_r;
            else prev_right_r <= rc_r;
            state_r <= S_TRAV;
          end
        end
        S_TRAV: begin
          if (side_r) left_trav_r <= 32'((mul_p_r + 66'sd128) >>> 8);
          else right_trav_r <= 32'((mul_p_r + 66'sd128) >>> 8);
          side_r  <= 1'b1;
          state_r <= side_r ? S_CHK : S_TICK;
        end
        S_CHK: begin
          held_r <= 1'b0;
          dist_r <= trav_sum[32:1];
          state_r <= track_r ? S_ARG : S_IDLE;
        end
        S_ARG: begin
          if (mul_p_r > 66'sh1_0000_0000 || mul_p_r < -66'sh1_0000_0000) begin
            held_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            neg_r <= asin_arg[17];
            m_r   <= arg_mag;
            if (arg_mag == 17'd0) begin
              angle_r <= '0;
              state_r <= S_MID;
            end else begin
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: state_r <= S_SQW;
        S_SQW: if (sq_done) state_r <= S_ASW;
        S_ASW: begin
          if (cor_done) begin
            angle_r <= neg_r ? cor_z[20:0] : -cor_z[20:0];
            state_r <= S_MID;
          end
        end
        S_MID: begin
          flip_r  <= (mid > ANG_HALF_PI) || (mid < -ANG_HALF_PI);
          state_r <= S_SCW;
        end
        S_SCW: if (cor_done) state_r <= S_PX;
        S_PX: state_r <= S_PY;
        S_PY: begin
          pose_x_r <= sat32(pos_sum);
          state_r  <= S_PH;
        end
        S_PH: begin
          pose_y_r <= sat32(pos_sum);
          head_r   <= 19'(wrap_ang(head_ext + angle_r));
          state_r  <= (el_r == 20'd0) ? S_OUT : S_DV1;
        end
        S_DV1: begin
          dneg_r  <= div_neg;
          state_r <= S_DW1;
        end
        S_DW1: begin
          if (div_done) begin
            spd_fwd_r <= speed_val;
            state_r   <= S_DV2;
          end
        end
        S_DV2: begin
          dneg_r  <= div_neg;
          state_r <= S_DW2;
        end
        S_DW2: begin
          if (div_done) begin
            spd_turn_r <= speed_val;
            state_r    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {5'b0, spd_turn_r, spd_fwd_r, head_r, pose_y_r, pose_x_r};
            out_user_r  <= held_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cor_busy && div_busy))
    else $error("cordic and divider busy together");

endmodule
